// ----- src/lzo_pkg.sv -----
// shared types and constants of the lzo-style decompressor
package lzo_pkg;

	localparam int WIN_DEPTH = 65536;
	localparam int WIN_AW    = 16;
	localparam int ALIGN_W   = 13;
	localparam int POS_W     = 32;
	localparam int LEN_W     = 9;

	// request from the sequencer to the output packer
	typedef struct packed {
		logic             emit;
		logic             flush;
		logic [7:0]       data;
		logic             err;
		logic [POS_W-1:0] total;
	} lzo_pack_req_t;

endpackage

// ----- src/lzo_in_if.sv -----
// compressed byte input channel
interface lzo_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- src/lzo_out_if.sv -----
// decompressed result channel
interface lzo_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic        out_last;
	logic        out_error;
	logic [31:0] out_total;

	modport source (output valid, output out_data, output out_count, output out_last,
		output out_error, output out_total, input ready);
	modport sink (input valid, input out_data, input out_count, input out_last,
		input out_error, input out_total, output ready);
endinterface

// ----- src/lzo_hist_ram.sv -----
// 64 KiB history window, one write port and one registered read port
module lzo_hist_ram
	import lzo_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [WIN_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [WIN_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [WIN_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/lzo_packer.sv -----
// packs emitted bytes into results and holds one result for the sink
module lzo_packer
	import lzo_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lzo_pack_req_t req,
	output logic          grant,
	lzo_out_if.source     dout
);

	logic [63:0]      pk_data_q;
	logic [3:0]       pk_cnt_q;
	logic             pk_err_q;
	logic             ov_q;
	logic [63:0]      o_data_q;
	logic [3:0]       o_cnt_q;
	logic             o_last_q;
	logic             o_err_q;
	logic [POS_W-1:0] o_tot_q;
	logic             slot_free;
	logic             full;
	logic             load_out;

	// grant and result transfer
	always_comb begin
		slot_free = !ov_q || dout.ready;
		full      = (pk_cnt_q == 4'(LANES));
		grant     = 1'b0;
		if (req.emit) begin
			grant = !full || slot_free;
		end else if (req.flush) begin
			grant = (pk_cnt_q == 4'd0) || slot_free;
		end
		load_out = grant && ((req.emit && full) || (req.flush && (pk_cnt_q != 4'd0)));
	end

	// pack and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q      <= 1'b0;
			pk_cnt_q  <= 4'd0;
			pk_err_q  <= 1'b0;
			pk_data_q <= 64'd0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (ov_q && dout.ready) begin
				ov_q <= 1'b0;
			end
			if (req.emit && grant) begin
				if (full) begin
					pk_data_q <= {56'd0, req.data};
					pk_cnt_q  <= 4'd1;
					pk_err_q  <= req.err;
				end else begin
					pk_data_q[pk_cnt_q[2:0]*8 +: 8] <= req.data;
					pk_cnt_q <= pk_cnt_q + 4'd1;
					pk_err_q <= pk_err_q | req.err;
				end
			end else if (req.flush && grant) begin
				pk_data_q <= 64'd0;
				pk_cnt_q  <= 4'd0;
				pk_err_q  <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			o_data_q <= pk_data_q;
			o_cnt_q  <= pk_cnt_q;
			o_err_q  <= pk_err_q;
			o_last_q <= req.flush;
			o_tot_q  <= req.total;
		end
	end

	assign dout.valid     = ov_q;
	assign dout.out_data  = o_data_q;
	assign dout.out_count = o_cnt_q;
	assign dout.out_last  = o_last_q;
	assign dout.out_error = o_err_q;
	assign dout.out_total = o_tot_q;

endmodule

// ----- src/lzo_style_stream_decompressor_core.sv -----
// top level: token parser, copy sequencer, history window and output packer
//
// Takes one compressed byte per input transaction and emits decompressed bytes packed up
// to OUT_LANES per result, the first byte in bits 7..0. A byte is taken only when the
// sequencer is waiting: a literal or operand byte is taken, decoded and closed; a
// back-reference adds a read and a write step per copied byte, reading it from and
// writing it to the 64 KiB history RAM before the next is read. A 0x12 token is held
// until three more bytes decide whether it is the alignment marker; replayed bytes come
// from the queue without new input. A waiting result stalls the sequencer when a byte
// meets a full packer or a flush a non-empty one. History is not cleared after reset.
module lzo_style_stream_decompressor_core
	import lzo_pkg::*;
#(
	parameter int OUT_LANES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	lzo_in_if.sink    din,
	lzo_out_if.source dout
);

	typedef enum logic [4:0] {
		ST_WAIT = 5'b00001,
		ST_FEED = 5'b00010,
		ST_CRD  = 5'b00100,
		ST_CWR  = 5'b01000,
		ST_END  = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_LITEXT, PH_LITS, PH_MEXT, PH_MD1, PH_MD2, PH_M64,
		PH_MARK0, PH_MARK1, PH_MARK2
	} phase_t;

	state_t             state_q, state_d;
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [ALIGN_W-1:0] off_q, off_d;
	logic [LEN_W-1:0]   mlen_q, mlen_d;
	logic [15:0]        dist_q, dist_d;
	logic [LEN_W-1:0]   lits_q, lits_d;
	logic               skip_q, skip_d;
	logic               last_q, last_d;
	logic               rep_q, rep_d;
	logic [7:0]         qb_q [4];
	logic [7:0]         qb_d [4];
	logic [2:0]         qcnt_q, qcnt_d;
	logic               qna_q, qna_d;

	lzo_pack_req_t      req;
	logic               grant;
	logic               rd_en;
	logic [WIN_AW-1:0]  rd_addr;
	logic [7:0]         rd_data;
	logic [7:0]         head;
	logic               do_pop;

	// sequencer and parser
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		pos_d   = pos_q;
		off_d   = off_q;
		mlen_d  = mlen_q;
		dist_d  = dist_q;
		lits_d  = lits_q;
		skip_d  = skip_q;
		last_d  = last_q;
		rep_d   = rep_q;
		qb_d    = qb_q;
		qcnt_d  = qcnt_q;
		qna_d   = qna_q;
		req       = '0;
		req.total = pos_q;
		rd_en     = 1'b0;
		rd_addr   = pos_q[WIN_AW-1:0] - dist_q;
		head      = qb_q[0];
		do_pop    = 1'b0;
		din.ready = (state_q == ST_WAIT);

		case (state_q)
			ST_WAIT: begin
				if (din.valid) begin
					off_d  = off_q + 1'b1;
					last_d = din.in_last;
					rep_d  = 1'b0;
					if (skip_q) begin
						if (off_d == '0) begin
							skip_d = 1'b0;
						end
						state_d = ST_END;
					end else begin
						qb_d[0] = din.in_byte;
						qcnt_d  = 3'd1;
						qna_d   = 1'b0;
						state_d = ST_FEED;
					end
				end
			end
			ST_FEED: begin
				do_pop = 1'b1;
				case (phase_q)
					PH_IDLE: begin
						if (head < 8'h10) begin
							if (head == 8'h00) begin
								phase_d = PH_LITEXT;
							end else begin
								lits_d  = LEN_W'(head) + 9'd3;
								phase_d = PH_LITS;
							end
						end else if (head < 8'h20) begin
							if (head == 8'h12 && !qna_q) begin
								phase_d = PH_MARK0;
							end else begin
								dist_d = head[3] ? 16'h8000 : 16'h4000;
								if (head[2:0] == 3'd0) begin
									phase_d = PH_MEXT;
								end else begin
									mlen_d  = (head[2:0] == 3'd1) ? '0 :
										LEN_W'(head[2:0]) + 9'd2;
									phase_d = PH_MD1;
								end
							end
						end else if (head < 8'h40) begin
							dist_d = 16'd1;
							if (head[4:0] == 5'd0) begin
								phase_d = PH_MEXT;
							end else begin
								mlen_d  = LEN_W'(head[4:0]) + 9'd2;
								phase_d = PH_MD1;
							end
						end else begin
							dist_d  = 16'(head[4:2]) + 16'd1;
							mlen_d  = LEN_W'(head[7:5]) + 9'd1;
							lits_d  = LEN_W'(head[1:0]);
							phase_d = PH_M64;
						end
					end
					PH_LITEXT: begin
						lits_d  = LEN_W'(head) + 9'd18;
						phase_d = PH_LITS;
					end
					PH_LITS: begin
						req.emit = 1'b1;
						req.data = head;
						if (grant) begin
							lits_d = (lits_q != '0) ? lits_q - 1'b1 : '0;
							if (lits_d == '0) begin
								phase_d = PH_IDLE;
							end
						end else begin
							do_pop = 1'b0;
						end
					end
					PH_MEXT: begin
						mlen_d  = (dist_q == 16'd1) ? LEN_W'(head) + 9'd33 :
							LEN_W'(head) + 9'd9;
						phase_d = PH_MD1;
					end
					PH_MD1: begin
						dist_d  = dist_q + 16'(head[7:2]);
						lits_d  = LEN_W'(head[1:0]);
						phase_d = PH_MD2;
					end
					PH_MD2: begin
						dist_d = dist_q + {head[7:0], 6'd0};
					end
					PH_M64: begin
						dist_d = dist_q + {5'd0, head, 3'd0};
					end
					PH_MARK0: begin
						if (head == 8'h00) begin
							phase_d = PH_MARK1;
						end else begin
							do_pop  = 1'b0;
							phase_d = PH_IDLE;
							qb_d[0] = 8'h12;
							qb_d[1] = head;
							qcnt_d  = 3'd2;
							qna_d   = 1'b1;
						end
					end
					PH_MARK1: begin
						if (head == 8'h00) begin
							phase_d = PH_MARK2;
						end else begin
							do_pop  = 1'b0;
							phase_d = PH_IDLE;
							qb_d[0] = 8'h12;
							qb_d[1] = 8'h00;
							qb_d[2] = head;
							qcnt_d  = 3'd3;
							qna_d   = 1'b1;
						end
					end
					PH_MARK2: begin
						phase_d = PH_IDLE;
						if (head == 8'hEE) begin
							// boundary inside the marker replays the check bytes
							if (off_q == ALIGN_W'(1)) begin
								do_pop = 1'b0;
							end else if (off_q == ALIGN_W'(2)) begin
								do_pop  = 1'b0;
								qb_d[0] = 8'h00;
								qb_d[1] = 8'hEE;
								qcnt_d  = 3'd2;
							end else if (off_q != '0) begin
								skip_d = 1'b1;
							end
						end else begin
							do_pop  = 1'b0;
							qb_d[0] = 8'h12;
							qb_d[1] = 8'h00;
							qb_d[2] = 8'h00;
							qb_d[3] = head;
							qcnt_d  = 3'd4;
							qna_d   = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
				if (do_pop) begin
					qb_d[0] = qb_q[1];
					qb_d[1] = qb_q[2];
					qb_d[2] = qb_q[3];
					qcnt_d  = qcnt_q - 3'd1;
					qna_d   = 1'b0;
					if (phase_q == PH_MD2 || phase_q == PH_M64) begin
						state_d = ST_CRD;
					end else if (qcnt_q == 3'd1) begin
						state_d = ST_END;
					end
				end
			end
			ST_CRD: begin
				// copy one byte: out of range bytes are zero and flagged
				if (mlen_q == '0) begin
					phase_d = (lits_q != '0) ? PH_LITS : PH_IDLE;
					state_d = (qcnt_q == 3'd0) ? ST_END : ST_FEED;
				end else if (pos_q < {16'd0, dist_q}) begin
					req.emit = 1'b1;
					req.err  = 1'b1;
					if (grant) begin
						mlen_d = mlen_q - 1'b1;
					end
				end else begin
					rd_en   = 1'b1;
					state_d = ST_CWR;
				end
			end
			ST_CWR: begin
				req.emit = 1'b1;
				req.data = rd_data;
				if (grant) begin
					mlen_d  = mlen_q - 1'b1;
					state_d = ST_CRD;
				end
			end
			ST_END: begin
				if (last_q && !rep_q &&
					(phase_q == PH_MARK0 || phase_q == PH_MARK1 || phase_q == PH_MARK2)) begin
					// pending 0x12 at end of stream replays as a plain match
					rep_d   = 1'b1;
					phase_d = PH_IDLE;
					qb_d[0] = 8'h12;
					qb_d[1] = 8'h00;
					qb_d[2] = 8'h00;
					qcnt_d  = (phase_q == PH_MARK0) ? 3'd1 :
						(phase_q == PH_MARK1) ? 3'd2 : 3'd3;
					qna_d   = 1'b1;
					state_d = ST_FEED;
				end else begin
					req.flush = 1'b1;
					if (grant) begin
						state_d = ST_WAIT;
						if (last_q) begin
							pos_d   = '0;
							off_d   = '0;
							phase_d = PH_IDLE;
							mlen_d  = '0;
							dist_d  = '0;
							lits_d  = '0;
							skip_d  = 1'b0;
						end
					end
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase

		if (req.emit && grant) begin
			pos_d = pos_q + 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			off_q   <= '0;
			mlen_q  <= '0;
			dist_q  <= '0;
			lits_q  <= '0;
			skip_q  <= 1'b0;
			last_q  <= 1'b0;
			rep_q   <= 1'b0;
			qcnt_q  <= '0;
			qna_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			off_q   <= off_d;
			mlen_q  <= mlen_d;
			dist_q  <= dist_d;
			lits_q  <= lits_d;
			skip_q  <= skip_d;
			last_q  <= last_d;
			rep_q   <= rep_d;
			qcnt_q  <= qcnt_d;
			qna_q   <= qna_d;
		end
	end

	// replay queue bytes
	always_ff @(posedge clk) begin
		qb_q <= qb_d;
	end

	lzo_hist_ram u_ram (
		.clk   (clk),
		.we    (req.emit && grant),
		.waddr (pos_q[WIN_AW-1:0]),
		.wdata (req.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lzo_packer #(
		.LANES (OUT_LANES)
	) u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.grant  (grant),
		.dout   (dout)
	);

	// checks
	a_qcnt: assert property (@(posedge clk) disable iff (!arst_n) qcnt_q <= 3'd4)
		else $error("replay queue overflow");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_END) |=> (pos_q == $past(pos_q) || pos_q == $past(pos_q) + 1'b1))
		else $error("output position jumped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.out_count != 4'd0 && dout.out_count <= 4'(OUT_LANES)))
		else $error("bad result count");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRD && rd_en) |=> (state_q == ST_CWR))
		else $error("copy read without write step");

endmodule
